/* rtl/core/bbm_pkg.sv */
// Package: shared types, pipeline depths and control struct of the billboard basis block.
package bbm_pkg;

    localparam int ISQ_STAGES = 31;                            // one root bit per stage
    localparam int DIV_STAGES = 17;                            // one quotient bit per stage
    localparam int PRE_STAGES = 6;                             // magnitude, max, lead, shift, square, sum
    localparam int NORM_LAT   = PRE_STAGES + ISQ_STAGES + DIV_STAGES + 1;
    localparam int SC_DLY     = NORM_LAT + 3;                  // scale wait up to the scale multiply

    localparam logic signed [29:0] HALF_LSB = 30'sd32768;

    typedef logic signed [31:0] coord_t;
    typedef logic        [30:0] scale_t;
    typedef logic signed [32:0] disp_t;
    typedef logic        [31:0] mag_t;
    typedef logic        [29:0] nmag_t;
    typedef logic        [61:0] sq_sum_t;
    typedef logic        [30:0] root_t;
    typedef logic        [16:0] quo_t;
    typedef logic signed [17:0] unit_t;
    typedef logic signed [20:0] up_t;

    typedef struct packed {
        logic en;   // advance every stage
        logic vld;  // transaction enters
    } pipe_ctl_t;

    typedef struct packed {
        scale_t x;
        scale_t y;
        scale_t z;
    } scale_set_t;

endpackage

/* rtl/core/bbm_in_if.sv */
// Interface: input channel carrying viewer position, object position and scale.
interface bbm_in_if
    import bbm_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t viewer_x;
    coord_t viewer_y;
    coord_t viewer_z;
    coord_t object_x;
    coord_t object_y;
    coord_t object_z;
    scale_t scale_x;
    scale_t scale_y;
    scale_t scale_z;

    modport source (output valid, viewer_x, viewer_y, viewer_z, object_x, object_y, object_z,
                    scale_x, scale_y, scale_z, input ready);
    modport sink   (input valid, viewer_x, viewer_y, viewer_z, object_x, object_y, object_z,
                    scale_x, scale_y, scale_z, output ready);
endinterface

/* rtl/core/bbm_out_if.sv */
// Interface: output channel carrying the scaled basis rows and the degenerate flag.
interface bbm_out_if
    import bbm_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t right_row_x;
    coord_t right_row_y;
    coord_t right_row_z;
    coord_t up_row_x;
    coord_t up_row_y;
    coord_t up_row_z;
    coord_t look_row_x;
    coord_t look_row_y;
    coord_t look_row_z;
    logic   degenerate;

    modport source (output valid, right_row_x, right_row_y, right_row_z, up_row_x, up_row_y,
                    up_row_z, look_row_x, look_row_y, look_row_z, degenerate, input ready);
    modport sink   (input valid, right_row_x, right_row_y, right_row_z, up_row_x, up_row_y,
                    up_row_z, look_row_x, look_row_y, look_row_z, degenerate, output ready);
endinterface

/* rtl/core/billboard_basis_matrix.sv */
// Top level: billboard basis matrix, viewer/object positions in, scaled basis rows out.
//
//  channel | modport     | transaction carries
//  --------+-------------+---------------------------------------------------------
//  pos     | bbm_in_if   | viewer xyz, object xyz (Q16.16), scale xyz (unsigned Q15.16)
//  basis   | bbm_out_if  | right/up/look rows (Q16.16, saturated), degenerate flag
//
// One transaction is accepted per cycle while the output is not stalled. The depth
// is set by the square root (31 stages) and the divider (17 stages) of the two
// normalizers that run side by side.
// All stages advance together on one enable; when the output register holds an
// untaken result the whole pipe holds, so nothing is lost or repeated.
// Reset clears only the valid bits.
module billboard_basis_matrix
    import bbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bbm_in_if.sink     pos,
    bbm_out_if.source  basis
);
    logic      en;
    pipe_ctl_t nctl;

    // subtract stage
    disp_t      d_reg [3];
    logic       vld0_reg;
    scale_set_t sc_reg [SC_DLY];

    disp_t      rv [3];
    unit_t      look [3];
    unit_t      right [3];
    logic       ok_d;
    logic       ok_r;
    logic       vld_l;
    logic       vld_r;

    // cross product stages
    logic signed [35:0] p_reg [6];
    unit_t      look1_reg  [3];
    unit_t      right1_reg [3];
    logic       deg1_reg;
    logic       vld1_reg;
    up_t        up2_reg    [3];
    unit_t      look2_reg  [3];
    unit_t      right2_reg [3];
    logic       deg2_reg;
    logic       vld2_reg;

    // scale multiply stage
    logic signed [52:0] pr_reg [9];
    logic       deg3_reg;
    logic       vld3_reg;

    // output register
    coord_t     row_reg [9];
    logic       deg4_reg;
    logic       vld4_reg;

    logic signed [36:0] up_sum [3];
    logic signed [52:0] rnd [9];
    scale_set_t sc_t;

    // the pipe moves unless a finished result waits
    assign en        = !vld4_reg || basis.ready;
    assign pos.ready = en;
    assign nctl      = '{en: en, vld: vld0_reg};

    // right = up x d = (dz, 0, -dx)
    assign rv[0] = d_reg[2];
    assign rv[1] = '0;
    assign rv[2] = -d_reg[0];
    assign sc_t  = sc_reg[SC_DLY-1];

    always_comb
    begin
        // round half up: add half an LSB, then floor
        up_sum[0] = (37'(p_reg[0]) - 37'(p_reg[1]) + 37'(HALF_LSB)) >>> 16;
        up_sum[1] = (37'(p_reg[2]) - 37'(p_reg[3]) + 37'(HALF_LSB)) >>> 16;
        up_sum[2] = (37'(p_reg[4]) - 37'(p_reg[5]) + 37'(HALF_LSB)) >>> 16;
        for (int i = 0; i < 9; i++)
        begin
            rnd[i] = (pr_reg[i] + 53'(HALF_LSB)) >>> 16;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= pos.valid;
            vld1_reg <= vld_l && vld_r;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= 33'(pos.object_x) - 33'(pos.viewer_x);
            d_reg[1] <= 33'(pos.object_y) - 33'(pos.viewer_y);
            d_reg[2] <= 33'(pos.object_z) - 33'(pos.viewer_z);
            sc_reg[0] <= '{x: pos.scale_x, y: pos.scale_y, z: pos.scale_z};
            for (int j = 1; j < SC_DLY; j++)
            begin
                sc_reg[j] <= sc_reg[j-1];
            end

            // up = look x right
            p_reg[0] <= 36'(look[1]) * 36'(right[2]);
            p_reg[1] <= 36'(look[2]) * 36'(right[1]);
            p_reg[2] <= 36'(look[2]) * 36'(right[0]);
            p_reg[3] <= 36'(look[0]) * 36'(right[2]);
            p_reg[4] <= 36'(look[0]) * 36'(right[1]);
            p_reg[5] <= 36'(look[1]) * 36'(right[0]);
            look1_reg  <= look;
            right1_reg <= right;
            deg1_reg   <= !(ok_d && ok_r);

            for (int i = 0; i < 3; i++)
            begin
                up2_reg[i] <= up_sum[i][20:0];
            end
            look2_reg  <= look1_reg;
            right2_reg <= right1_reg;
            deg2_reg   <= deg1_reg;

            for (int i = 0; i < 3; i++)
            begin
                pr_reg[i]     <= 53'(right2_reg[i]) * 53'($signed({1'b0, sc_t.x}));
                pr_reg[3 + i] <= 53'(up2_reg[i])    * 53'($signed({1'b0, sc_t.y}));
                pr_reg[6 + i] <= 53'(look2_reg[i])  * 53'($signed({1'b0, sc_t.z}));
            end
            deg3_reg <= deg2_reg;

            // saturate to the signed 32-bit range
            for (int i = 0; i < 9; i++)
            begin
                priority if (rnd[i] > 53'sh7FFFFFFF)
                begin
                    row_reg[i] <= 32'sh7FFFFFFF;
                end
                else if (rnd[i] < -53'sh80000000)
                begin
                    row_reg[i] <= 32'sh80000000;
                end
                else
                begin
                    row_reg[i] <= rnd[i][31:0];
                end
            end
            deg4_reg <= deg3_reg;
        end
    end

    bbm_norm u_norm_look (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (nctl),
        .v       (d_reg),
        .u       (look),
        .ok      (ok_d),
        .vld_out (vld_l)
    );

    bbm_norm u_norm_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (nctl),
        .v       (rv),
        .u       (right),
        .ok      (ok_r),
        .vld_out (vld_r)
    );

    assign basis.valid       = vld4_reg;
    assign basis.right_row_x = row_reg[0];
    assign basis.right_row_y = row_reg[1];
    assign basis.right_row_z = row_reg[2];
    assign basis.up_row_x    = row_reg[3];
    assign basis.up_row_y    = row_reg[4];
    assign basis.up_row_z    = row_reg[5];
    assign basis.look_row_x  = row_reg[6];
    assign basis.look_row_y  = row_reg[7];
    assign basis.look_row_z  = row_reg[8];
    assign basis.degenerate  = deg4_reg;
endmodule

/* rtl/core/bbm_isqrt.sv */
// Module: pipelined integer square root, one result bit per stage.
module bbm_isqrt
    import bbm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pipe_ctl_t ctl,
    input  sq_sum_t   n_in,
    output root_t     root,
    output logic      vld_out
);
    sq_sum_t n_reg   [ISQ_STAGES];
    sq_sum_t res_reg [ISQ_STAGES];
    logic    vld_reg [ISQ_STAGES];

    for (genvar gi = 0; gi < ISQ_STAGES; gi++) begin : g_stage
        localparam sq_sum_t BIT_V = sq_sum_t'(1) << (60 - 2 * gi);
        sq_sum_t n_p;
        sq_sum_t res_p;
        sq_sum_t trial;
        logic    v_p;
        logic    ge;

        if (gi == 0) begin : g_first
            assign n_p   = n_in;
            assign res_p = '0;
            assign v_p   = ctl.vld;
        end
        else begin : g_next
            assign n_p   = n_reg[gi-1];
            assign res_p = res_reg[gi-1];
            assign v_p   = vld_reg[gi-1];
        end

        assign trial = res_p + BIT_V;
        assign ge    = (n_p >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[gi] <= 1'b0;
            end
            else if (ctl.en)
            begin
                vld_reg[gi] <= v_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                n_reg[gi]   <= ge ? n_p - trial : n_p;
                res_reg[gi] <= ge ? (res_p >> 1) + BIT_V : res_p >> 1;
            end
        end
    end

    assign root    = res_reg[ISQ_STAGES-1][30:0];
    assign vld_out = vld_reg[ISQ_STAGES-1];
endmodule

/* rtl/core/bbm_div.sv */
// Module: pipelined restoring divider, (num * 2^16) / den, one quotient bit per stage.
module bbm_div
    import bbm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pipe_ctl_t ctl,
    input  nmag_t     num,
    input  root_t     den,
    output quo_t      q,
    output logic      vld_out
);
    logic [46:0] rem_reg [DIV_STAGES];
    root_t       den_reg [DIV_STAGES];
    quo_t        q_reg   [DIV_STAGES];
    logic        vld_reg [DIV_STAGES];

    for (genvar gj = 0; gj < DIV_STAGES; gj++) begin : g_stage
        localparam int K = DIV_STAGES - 1 - gj;
        logic [46:0] rem_p;
        root_t       den_p;
        quo_t        q_p;
        logic        v_p;
        logic [46:0] dsh;
        logic        ge;

        if (gj == 0) begin : g_first
            assign rem_p = {1'b0, num, 16'd0};
            assign den_p = den;
            assign q_p   = '0;
            assign v_p   = ctl.vld;
        end
        else begin : g_next
            assign rem_p = rem_reg[gj-1];
            assign den_p = den_reg[gj-1];
            assign q_p   = q_reg[gj-1];
            assign v_p   = vld_reg[gj-1];
        end

        assign dsh = 47'(den_p) << K;
        assign ge  = (rem_p >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[gj] <= 1'b0;
            end
            else if (ctl.en)
            begin
                vld_reg[gj] <= v_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[gj] <= ge ? rem_p - dsh : rem_p;
                den_reg[gj] <= den_p;
                q_reg[gj]   <= {q_p[15:0], ge};
            end
        end
    end

    assign q       = q_reg[DIV_STAGES-1];
    assign vld_out = vld_reg[DIV_STAGES-1];
endmodule

/* rtl/core/bbm_norm.sv */
// Module: pipelined normalizer of a 3-vector to a signed Q1.16 unit vector.
module bbm_norm
    import bbm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pipe_ctl_t ctl,
    input  disp_t     v [3],
    output unit_t     u [3],
    output logic      ok,
    output logic      vld_out
);
    localparam int MAG_DLY = 2 + ISQ_STAGES;

    // stage A: magnitudes and signs
    mag_t       mag_a_reg [3];
    logic [2:0] neg_a_reg;
    // stage B: largest magnitude
    mag_t       mag_b_reg [3];
    mag_t       m_b_reg;
    logic [2:0] neg_b_reg;
    // stage C: shift amounts
    mag_t       mag_c_reg [3];
    logic [4:0] shr_c_reg;
    logic [4:0] shl_c_reg;
    logic       zero_c_reg;
    logic [2:0] neg_c_reg;
    // stage D: scaled magnitudes
    nmag_t      mag_d_reg [3];
    logic       zero_d_reg;
    logic [2:0] neg_d_reg;
    // stage E: squares, stage F: sum
    logic [59:0] sq_e_reg [3];
    sq_sum_t     sum_f_reg;
    logic [PRE_STAGES-1:0] vld_pre_reg;

    // magnitudes wait for the root
    nmag_t      mag_w_reg  [MAG_DLY][3];
    logic       zero_w_reg [MAG_DLY];
    logic [2:0] neg_w_reg  [MAG_DLY];
    // signs wait for the quotient
    logic       zero_q_reg [DIV_STAGES];
    logic [2:0] neg_q_reg  [DIV_STAGES];

    unit_t      u_reg [3];
    logic       ok_reg;
    logic       vld_u_reg;

    root_t      root;
    logic       root_vld;
    quo_t       qv [3];
    logic [2:0] q_vld;

    mag_t       m_next;
    logic [4:0] lead;

    always_comb
    begin
        m_next = mag_a_reg[0];
        if (mag_a_reg[1] > m_next)
        begin
            m_next = mag_a_reg[1];
        end
        if (mag_a_reg[2] > m_next)
        begin
            m_next = mag_a_reg[2];
        end
    end

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (m_b_reg[i])
            begin
                lead = 5'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_pre_reg <= '0;
        end
        else if (ctl.en)
        begin
            vld_pre_reg <= {vld_pre_reg[PRE_STAGES-2:0], ctl.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg_a_reg[i] <= v[i][32];
                mag_a_reg[i] <= v[i][32] ? 32'(-v[i]) : 32'(v[i]);
                mag_b_reg[i] <= mag_a_reg[i];
                mag_c_reg[i] <= mag_b_reg[i];
                mag_d_reg[i] <= 30'((mag_c_reg[i] >> shr_c_reg) << shl_c_reg);
                sq_e_reg[i]  <= 60'(mag_d_reg[i]) * 60'(mag_d_reg[i]);
            end
            m_b_reg    <= m_next;
            neg_b_reg  <= neg_a_reg;
            zero_c_reg <= (m_b_reg == '0);
            shr_c_reg  <= (lead >= 5'd29) ? lead - 5'd29 : 5'd0;
            shl_c_reg  <= (lead <  5'd29) ? 5'd29 - lead : 5'd0;
            neg_c_reg  <= neg_b_reg;
            zero_d_reg <= zero_c_reg;
            neg_d_reg  <= neg_c_reg;
            sum_f_reg  <= 62'(sq_e_reg[0]) + 62'(sq_e_reg[1]) + 62'(sq_e_reg[2]);

            mag_w_reg[0]  <= mag_d_reg;
            zero_w_reg[0] <= zero_d_reg;
            neg_w_reg[0]  <= neg_d_reg;
            for (int j = 1; j < MAG_DLY; j++)
            begin
                mag_w_reg[j]  <= mag_w_reg[j-1];
                zero_w_reg[j] <= zero_w_reg[j-1];
                neg_w_reg[j]  <= neg_w_reg[j-1];
            end

            zero_q_reg[0] <= zero_w_reg[MAG_DLY-1];
            neg_q_reg[0]  <= neg_w_reg[MAG_DLY-1];
            for (int j = 1; j < DIV_STAGES; j++)
            begin
                zero_q_reg[j] <= zero_q_reg[j-1];
                neg_q_reg[j]  <= neg_q_reg[j-1];
            end

            for (int i = 0; i < 3; i++)
            begin
                if (zero_q_reg[DIV_STAGES-1])
                begin
                    u_reg[i] <= '0;
                end
                else if (neg_q_reg[DIV_STAGES-1][i])
                begin
                    u_reg[i] <= -unit_t'({1'b0, qv[i]});
                end
                else
                begin
                    u_reg[i] <= unit_t'({1'b0, qv[i]});
                end
            end
            ok_reg <= !zero_q_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_u_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            vld_u_reg <= q_vld[0];
        end
    end

    bbm_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     ('{en: ctl.en, vld: vld_pre_reg[PRE_STAGES-1]}),
        .n_in    (sum_f_reg),
        .root    (root),
        .vld_out (root_vld)
    );

    for (genvar gl = 0; gl < 3; gl++) begin : g_lane
        bbm_div u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     ('{en: ctl.en, vld: root_vld}),
            .num     (mag_w_reg[MAG_DLY-1][gl]),
            .den     (root),
            .q       (qv[gl]),
            .vld_out (q_vld[gl])
        );
    end

    assign u       = u_reg;
    assign ok      = ok_reg;
    assign vld_out = vld_u_reg;
endmodule

/* rtl/core/bbm_checker.sv */
// Checker: port-level assertions for the billboard basis block, bound to the top level.
module bbm_checker
    import bbm_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input coord_t right_x,
    input coord_t right_y,
    input coord_t right_z,
    input coord_t up_x,
    input coord_t up_y,
    input coord_t up_z,
    input logic   degenerate
);
    // hold an untaken result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(right_x) && $stable(up_z))
        else $error("result dropped or changed while stalled");

    // intake stalls only behind a stalled output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("intake ready does not follow output stall");

    // degenerate basis has no right axis, hence no up axis
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> right_x == 0 && right_y == 0 && right_z == 0 &&
                                    up_x == 0 && up_y == 0 && up_z == 0)
        else $error("degenerate result with nonzero right or up row");

    // right axis lies in the horizontal plane
    a_flat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> right_y == 0)
        else $error("right row has a vertical component");
endmodule

bind billboard_basis_matrix bbm_checker u_bbm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (pos.ready),
    .out_valid  (basis.valid),
    .out_ready  (basis.ready),
    .right_x    (basis.right_row_x),
    .right_y    (basis.right_row_y),
    .right_z    (basis.right_row_z),
    .up_x       (basis.up_row_x),
    .up_y       (basis.up_row_y),
    .up_z       (basis.up_row_z),
    .degenerate (basis.degenerate)
);
